// ===== src/afd_pkg.sv =====
// Package for the API frame deframer: types, codes, constants and helper functions.
package afd_pkg;

   localparam logic [7:0]  START_BYTE = 8'h7E;
   localparam logic [7:0]  SUM_INIT   = 8'hFF;

   // shortest legal body per frame kind (type byte included)
   localparam logic [15:0] AT_MIN_BODY    = 16'd5;
   localparam logic [15:0] MODEM_MIN_BODY = 16'd2;
   localparam logic [15:0] TX_MIN_BODY    = 16'd7;
   localparam logic [15:0] RX_MIN_BODY    = 16'd12;
   localparam logic [15:0] ANY_MIN_BODY   = 16'd1;

   // body positions of fixed header bytes
   localparam logic [15:0] RX_ADDR64_LAST = 16'd8;

   localparam logic [7:0]  AT_RESET_CODE    = 8'h88;
   localparam logic [7:0]  MODEM_RESET_CODE = 8'h8A;
   localparam logic [7:0]  TX_RESET_CODE    = 8'h8B;
   localparam logic [7:0]  RX_RESET_CODE    = 8'h90;

   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic ITEM_DATA    = 1'b0;
   localparam logic ITEM_SUMMARY = 1'b1;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_BODY,
      PH_CSUM
   } phase_type;

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_AT,
      KIND_MODEM,
      KIND_TX,
      KIND_RX
   } kind_type;

   typedef enum logic [1:0] {
      ERR_OK,
      ERR_CHECKSUM,
      ERR_UNKNOWN,
      ERR_SHORT
   } error_type;

   typedef enum logic [1:0] {
      REG_AT,
      REG_MODEM,
      REG_TX,
      REG_RX
   } reg_index_type;

   typedef struct packed {
      logic [7:0] at_code;
      logic [7:0] modem_code;
      logic [7:0] tx_code;
      logic [7:0] rx_code;
   } type_codes_type;

   typedef struct packed {
      logic        item_kind;
      logic [7:0]  data_byte;
      logic [7:0]  frame_type;
      logic [1:0]  error_code;
      logic [7:0]  frame_id;
      logic [15:0] at_command;
      logic [7:0]  status_value;
      logic [63:0] source_addr64;
      logic [15:0] short_addr;
      logic [7:0]  retry_or_options;
      logic [7:0]  discovery_status;
      logic [15:0] payload_length;
   } result_type;

   // first match wins when codes coincide
   function automatic kind_type classify(input logic [7:0] t, input type_codes_type c);
      kind_type k;
      priority if (t == c.at_code) begin
         k = KIND_AT;
      end else if (t == c.modem_code) begin
         k = KIND_MODEM;
      end else if (t == c.tx_code) begin
         k = KIND_TX;
      end else if (t == c.rx_code) begin
         k = KIND_RX;
      end else begin
         k = KIND_NONE;
      end
      return k;
   endfunction

   function automatic logic [15:0] min_body(input kind_type k);
      logic [15:0] m;
      unique case (k)
         KIND_AT:    m = AT_MIN_BODY;
         KIND_MODEM: m = MODEM_MIN_BODY;
         KIND_TX:    m = TX_MIN_BODY;
         KIND_RX:    m = RX_MIN_BODY;
         default:    m = ANY_MIN_BODY;
      endcase
      return m;
   endfunction

endpackage

// ===== src/afd_csr.sv =====
// Frame type code registers behind the APB-style configuration port.
module afd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [afd_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [afd_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [afd_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready,
   output afd_pkg::type_codes_type            codes
);
   import afd_pkg::*;

   type_codes_type codes_ff;
   type_codes_type codes_in;
   reg_index_type  index;
   logic           wr_en;
   logic [7:0]     rd_byte;

   assign index = reg_index_type'(paddr[3:2]);
   assign wr_en = psel && penable && pwrite;
   assign pready = 1'b1;
   assign codes = codes_ff;

   always_comb begin
      codes_in = codes_ff;
      if (wr_en) begin
         unique case (index)
            REG_AT:    codes_in.at_code    = pwdata[7:0];
            REG_MODEM: codes_in.modem_code = pwdata[7:0];
            REG_TX:    codes_in.tx_code    = pwdata[7:0];
            REG_RX:    codes_in.rx_code    = pwdata[7:0];
            default:   codes_in = codes_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_AT:    rd_byte = codes_ff.at_code;
         REG_MODEM: rd_byte = codes_ff.modem_code;
         REG_TX:    rd_byte = codes_ff.tx_code;
         REG_RX:    rd_byte = codes_ff.rx_code;
         default:   rd_byte = 8'h00;
      endcase
      prdata = {{(CSR_DATA_W-8){1'b0}}, rd_byte};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff.at_code    <= AT_RESET_CODE;
         codes_ff.modem_code <= MODEM_RESET_CODE;
         codes_ff.tx_code    <= TX_RESET_CODE;
         codes_ff.rx_code    <= RX_RESET_CODE;
      end else begin
         codes_ff <= codes_in;
      end
   end

endmodule

// ===== src/afd_parser.sv =====
// Frame state machine: tracks phase, length, checksum and header fields per byte.
module afd_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              rx_byte,
   input  afd_pkg::type_codes_type codes,
   output logic                    emit,
   output afd_pkg::result_type     result
);
   import afd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] pos_ff, pos_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  id_ff, id_in;
   logic [15:0] cmd_ff, cmd_in;
   logic [7:0]  status_ff, status_in;
   logic [63:0] addr64_ff, addr64_in;
   logic [15:0] addr16_ff, addr16_in;
   logic [7:0]  misc_ff, misc_in;
   logic [7:0]  disc_ff, disc_in;

   kind_type    kind_body;
   kind_type    kind_csum;
   logic [15:0] new_length;
   logic        short_frame;

   assign kind_body  = classify(type_ff, codes);
   assign kind_csum  = (length_ff == 16'd0) ? KIND_NONE : kind_body;
   assign new_length = {length_ff[15:8], rx_byte};
   assign short_frame = (length_ff == 16'd0) || (length_ff < min_body(kind_csum));

   always_comb begin
      phase_in  = phase_ff;
      length_in = length_ff;
      pos_in    = pos_ff;
      sum_in    = sum_ff;
      type_in   = type_ff;
      id_in     = id_ff;
      cmd_in    = cmd_ff;
      status_in = status_ff;
      addr64_in = addr64_ff;
      addr16_in = addr16_ff;
      misc_in   = misc_ff;
      disc_in   = disc_ff;
      emit      = 1'b0;
      result    = '0;

      unique case (phase_ff)
         PH_LEN_HI: begin
            length_in = {rx_byte, 8'h00};
            phase_in  = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            length_in = new_length;
            pos_in    = 16'd0;
            sum_in    = SUM_INIT;
            type_in   = 8'h00;
            id_in     = 8'h00;
            cmd_in    = 16'h0000;
            status_in = 8'h00;
            addr64_in = 64'h0;
            addr16_in = 16'h0000;
            misc_in   = 8'h00;
            disc_in   = 8'h00;
            phase_in  = (new_length == 16'd0) ? PH_CSUM : PH_BODY;
         end
         PH_BODY: begin
            sum_in = sum_ff - rx_byte;
            if (pos_ff == 16'd0) begin
               type_in = rx_byte;
            end else begin
               unique case (kind_body)
                  KIND_AT: begin
                     priority if (pos_ff == 16'd1) id_in = rx_byte;
                     else if (pos_ff == 16'd2) cmd_in = {rx_byte, cmd_ff[7:0]};
                     else if (pos_ff == 16'd3) cmd_in = {cmd_ff[15:8], rx_byte};
                     else if (pos_ff == 16'd4) status_in = rx_byte;
                     else emit = 1'b1;
                  end
                  KIND_MODEM: begin
                     if (pos_ff == 16'd1) status_in = rx_byte;
                  end
                  KIND_TX: begin
                     priority if (pos_ff == 16'd1) id_in = rx_byte;
                     else if (pos_ff == 16'd2) addr16_in = {rx_byte, addr16_ff[7:0]};
                     else if (pos_ff == 16'd3) addr16_in = {addr16_ff[15:8], rx_byte};
                     else if (pos_ff == 16'd4) misc_in = rx_byte;
                     else if (pos_ff == 16'd5) status_in = rx_byte;
                     else if (pos_ff == 16'd6) disc_in = rx_byte;
                     else disc_in = disc_ff;
                  end
                  KIND_RX: begin
                     priority if (pos_ff <= RX_ADDR64_LAST) addr64_in = {addr64_ff[55:0], rx_byte};
                     else if (pos_ff == 16'd9) addr16_in = {rx_byte, addr16_ff[7:0]};
                     else if (pos_ff == 16'd10) addr16_in = {addr16_ff[15:8], rx_byte};
                     else if (pos_ff == 16'd11) misc_in = rx_byte;
                     else emit = 1'b1;
                  end
                  default: begin
                     emit = 1'b0;
                  end
               endcase
            end
            pos_in = pos_ff + 16'd1;
            if (pos_in == length_ff) phase_in = PH_CSUM;
            if (emit) begin
               result.item_kind  = ITEM_DATA;
               result.data_byte  = rx_byte;
               result.frame_type = type_ff;
            end
         end
         PH_CSUM: begin
            emit = 1'b1;
            result.item_kind  = ITEM_SUMMARY;
            result.frame_type = type_ff;
            priority if (rx_byte != sum_ff) result.error_code = ERR_CHECKSUM;
            else if (kind_csum == KIND_NONE && length_ff != 16'd0)
               result.error_code = ERR_UNKNOWN;
            else if (short_frame) result.error_code = ERR_SHORT;
            else result.error_code = ERR_OK;
            unique case (kind_csum)
               KIND_AT: begin
                  result.frame_id     = id_ff;
                  result.at_command   = cmd_ff;
                  result.status_value = status_ff;
                  if (!short_frame) result.payload_length = length_ff - AT_MIN_BODY;
               end
               KIND_MODEM: begin
                  result.status_value = status_ff;
               end
               KIND_TX: begin
                  result.frame_id         = id_ff;
                  result.status_value     = status_ff;
                  result.short_addr       = addr16_ff;
                  result.retry_or_options = misc_ff;
                  result.discovery_status = disc_ff;
               end
               KIND_RX: begin
                  result.source_addr64    = addr64_ff;
                  result.short_addr       = addr16_ff;
                  result.retry_or_options = misc_ff;
                  if (!short_frame) result.payload_length = length_ff - RX_MIN_BODY;
               end
               default: begin
                  result.payload_length = 16'd0;
               end
            endcase
            phase_in = PH_HUNT;
         end
         default: begin
            phase_in = (rx_byte == START_BYTE) ? PH_LEN_HI : PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
      end else if (step) begin
         phase_ff <= phase_in;
      end
   end

   // frame context, always rewritten at the length low byte before use
   always_ff @(posedge clock) begin
      if (step) begin
         length_ff <= length_in;
         pos_ff    <= pos_in;
         sum_ff    <= sum_in;
         type_ff   <= type_in;
         id_ff     <= id_in;
         cmd_ff    <= cmd_in;
         status_ff <= status_in;
         addr64_ff <= addr64_in;
         addr16_ff <= addr16_in;
         misc_ff   <= misc_in;
         disc_ff   <= disc_in;
      end
   end

endmodule

// ===== src/api_frame_deframer_core.sv =====
// Top level of the API frame deframer: handshakes, result register and CSR block.
//
//  channel  direction  handshake            payload
//  req_     in         req_valid/req_ready  req_rx_byte
//  rsp_     out        rsp_valid/rsp_ready  rsp_item_kind .. rsp_payload_length
//  csr      in/out     psel/penable/pready  paddr, pwdata, prdata (4 x 8-bit codes)
//
// One byte per cycle while the result register can take it: each transfer is
// handled combinationally by the frame FSM and its result (if any) lands in the output register on that edge.
// The rate is bounded only by the single result register: a new byte is taken
// whenever that register is empty or is being drained in the same cycle.
// Synchronous reset returns the FSM to start-byte hunting and the type codes
// to their defaults; no clearing pass is needed.
// A stalled result holds the input back only while it cannot be drained.
module api_frame_deframer_core (
   input  logic                           clock,
   input  logic                           reset,
   // byte input
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_rx_byte,
   // result output
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_item_kind,
   output logic [7:0]                     rsp_data_byte,
   output logic [7:0]                     rsp_frame_type,
   output logic [1:0]                     rsp_error_code,
   output logic [7:0]                     rsp_frame_id,
   output logic [15:0]                    rsp_at_command,
   output logic [7:0]                     rsp_status_value,
   output logic [63:0]                    rsp_source_addr64,
   output logic [15:0]                    rsp_short_addr,
   output logic [7:0]                     rsp_retry_or_options,
   output logic [7:0]                     rsp_discovery_status,
   output logic [15:0]                    rsp_payload_length,
   // configuration
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [afd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [afd_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [afd_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import afd_pkg::*;

   type_codes_type codes;
   result_type     result;
   result_type     rsp_ff;
   logic           emit;
   logic           req_fire;
   logic           rsp_valid_ff, rsp_valid_in;

   afd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .codes   (codes)
   );

   afd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (req_fire),
      .rx_byte (req_rx_byte),
      .codes   (codes),
      .emit    (emit),
      .result  (result)
   );

   // take a byte when the result slot is free or frees up this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_item_kind        = rsp_ff.item_kind;
   assign rsp_data_byte        = rsp_ff.data_byte;
   assign rsp_frame_type       = rsp_ff.frame_type;
   assign rsp_error_code       = rsp_ff.error_code;
   assign rsp_frame_id         = rsp_ff.frame_id;
   assign rsp_at_command       = rsp_ff.at_command;
   assign rsp_status_value     = rsp_ff.status_value;
   assign rsp_source_addr64    = rsp_ff.source_addr64;
   assign rsp_short_addr       = rsp_ff.short_addr;
   assign rsp_retry_or_options = rsp_ff.retry_or_options;
   assign rsp_discovery_status = rsp_ff.discovery_status;
   assign rsp_payload_length   = rsp_ff.payload_length;

endmodule
